>>> rtl/ebrc_pkg.sv
// ----------------------------------------------------------------------------
// ebrc_pkg
// Types, opcodes, status codes and constants of the 8-bit core.
// ----------------------------------------------------------------------------
package ebrc_pkg;

  typedef struct packed {
    logic       command;
    logic [7:0] load_address;
    logic [7:0] load_data;
    logic [7:0] key_char;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  screen_char;
    logic        screen_valid;
    logic [7:0]  program_counter;
    logic [31:0] tick_count;
  } out_item_t;

  localparam logic       CMD_LOAD = 1'b0;
  localparam logic [7:0] KEY_ADDR = 8'd254;
  localparam logic [7:0] SCREEN_ADDR = 8'd255;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_SCREEN = 4'd1;
  localparam logic [3:0] ST_KEY_WAIT = 4'd2;
  localparam logic [3:0] ST_RETURNED = 4'd3;
  localparam logic [3:0] ST_BAD_PC = 4'd4;
  localparam logic [3:0] ST_DIV_ZERO = 4'd5;
  localparam logic [3:0] ST_JUMP_RANGE = 4'd6;
  localparam logic [3:0] ST_LOAD_RANGE = 4'd7;
  localparam logic [3:0] ST_STORE_RANGE = 4'd8;
  localparam logic [3:0] ST_PUSH_OVF = 4'd9;
  localparam logic [3:0] ST_POP_UNF = 4'd10;
  localparam logic [3:0] ST_CALL_OVF = 4'd11;
  localparam logic [3:0] ST_CALL_RANGE = 4'd12;
  localparam logic [3:0] ST_HALTED = 4'd13;

  localparam logic [4:0] OP_MOV_RR = 5'd0;
  localparam logic [4:0] OP_MOV_RI = 5'd1;
  localparam logic [4:0] OP_ADD_RR = 5'd2;
  localparam logic [4:0] OP_ADD_RI = 5'd3;
  localparam logic [4:0] OP_SUB_RR = 5'd4;
  localparam logic [4:0] OP_SUB_RI = 5'd5;
  localparam logic [4:0] OP_MUL_RR = 5'd6;
  localparam logic [4:0] OP_MUL_RI = 5'd7;
  localparam logic [4:0] OP_DIV_RR = 5'd8;
  localparam logic [4:0] OP_DIV_RI = 5'd9;
  localparam logic [4:0] OP_CMP_RR = 5'd10;
  localparam logic [4:0] OP_CMP_RI = 5'd11;
  localparam logic [4:0] OP_JMP = 5'd12;
  localparam logic [4:0] OP_JEQ = 5'd13;
  localparam logic [4:0] OP_JNE = 5'd14;
  localparam logic [4:0] OP_JGR = 5'd15;
  localparam logic [4:0] OP_JLS = 5'd16;
  localparam logic [4:0] OP_CALL = 5'd17;
  localparam logic [4:0] OP_RET = 5'd18;
  localparam logic [4:0] OP_AND_RR = 5'd19;
  localparam logic [4:0] OP_AND_RI = 5'd20;
  localparam logic [4:0] OP_OR_RR = 5'd21;
  localparam logic [4:0] OP_OR_RI = 5'd22;
  localparam logic [4:0] OP_XOR_RR = 5'd23;
  localparam logic [4:0] OP_XOR_RI = 5'd24;
  localparam logic [4:0] OP_NEG = 5'd25;
  localparam logic [4:0] OP_LOAD = 5'd26;
  localparam logic [4:0] OP_LOADP = 5'd27;
  localparam logic [4:0] OP_STOR = 5'd28;
  localparam logic [4:0] OP_STORP = 5'd29;
  localparam logic [4:0] OP_PUSH = 5'd30;
  localparam logic [4:0] OP_POP = 5'd31;

  // RAM address select
  typedef enum logic [1:0] {
    ADDR_PC,
    ADDR_PC1,
    ADDR_EXEC
  } addr_sel_e;

  // controller -> datapath
  typedef struct packed {
    logic      ram_read;
    addr_sel_e addr_sel;
    logic      latch_hi;
    logic      latch_lo;
    logic      div_start;
    logic      exec_commit;  // retire the fetched instruction
    logic      bad_pc;       // retire with bad PC error
    logic      do_load;      // load command
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       pc_ok;
    logic       needs_mem;   // instruction reads RAM in exec
    logic       needs_div;
    logic       div_done;
    logic       halted;
  } dp_stat_t;

endpackage

>>> rtl/ebrc_ram.sv
// ----------------------------------------------------------------------------
// ebrc_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ebrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 254
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end
endmodule

>>> rtl/ebrc_div.sv
// ----------------------------------------------------------------------------
// ebrc_div
// Iterative 8-bit restoring divider, one quotient bit per cycle.
// Quotient magnitude only; sign is applied by the caller.
// ----------------------------------------------------------------------------
module ebrc_div (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] num_i,
  input  logic [7:0] den_i,
  output logic       done_o,
  output logic [7:0] quot_o
);
  logic [3:0] cnt_q, cnt_d;
  logic [7:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [8:0] trial;
  logic       busy_q, busy_d, done_q, done_d;

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[7]} - {1'b0, den_q};
    if (start_i) begin
      cnt_d  = 4'd8;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[8]) begin
        rem_d = trial[7:0];
        quo_d = {quo_q[6:0], 1'b1};
      end else begin
        rem_d = {rem_q[6:0], quo_q[7]};
        quo_d = {quo_q[6:0], 1'b0};
      end
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

>>> rtl/ebrc_datapath.sv
// ----------------------------------------------------------------------------
// ebrc_datapath
// Registers, PC, SP, flags, RAM, divider and the execute logic.
// ----------------------------------------------------------------------------
module ebrc_datapath #(
  parameter int RAM_BYTES = 254
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ebrc_pkg::in_item_t  item_i,
  input  ebrc_pkg::dp_cmd_t   cmd_i,
  output ebrc_pkg::dp_stat_t  stat_o,
  output ebrc_pkg::out_item_t res_o
);
  import ebrc_pkg::*;

  localparam int AW = $clog2(RAM_BYTES);
  localparam logic [7:0] RAM_TOP = 8'(RAM_BYTES);
  localparam logic [7:0] PC_MAX = 8'(RAM_BYTES - 2);

  logic [7:0]  regs_q [8];
  logic [7:0]  pc_q, sp_q, hi_q, lo_q;
  logic        zf_q, sf_q, halt_q;
  logic [31:0] tick_q;

  logic [7:0] ram_rdata, ram_addr8, ram_wdata;
  logic       ram_we;

  logic [4:0] op;
  logic [2:0] dr, sr;
  logic [7:0] rd, rs, mem_addr, store_addr, store_val, alu_res;
  logic       alu_wr, flag_wr;
  logic [7:0] div_den, div_q;
  logic       div_done;
  logic [7:0] div_res;

  assign op = hi_q[7:3];
  assign dr = hi_q[2:0];
  assign sr = lo_q[2:0];
  assign rd = regs_q[dr];
  assign rs = regs_q[sr];
  assign mem_addr = (op == OP_LOAD) ? lo_q : rs;
  assign store_addr = (op == OP_STOR) ? lo_q : rd;
  assign store_val = (op == OP_STOR) ? rd : rs;

  // divider: DIV ri uses the magnitude of the signed immediate
  assign div_den = (op == OP_DIV_RR) ? rs : (lo_q[7] ? 8'(-lo_q) : lo_q);
  assign div_res = (op == OP_DIV_RI && lo_q[7]) ? 8'(-div_q) : div_q;

  ebrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (rd),
    .den_i  (div_den),
    .done_o (div_done),
    .quot_o (div_q)
  );

  always_comb begin
    unique case (cmd_i.addr_sel)
      ADDR_PC:  ram_addr8 = pc_q;
      ADDR_PC1: ram_addr8 = 8'(pc_q + 8'd1);
      default: begin
        if (cmd_i.do_load) ram_addr8 = item_i.load_address;
        else if (op == OP_RET || op == OP_POP) ram_addr8 = sp_q;
        else if (op == OP_CALL || op == OP_PUSH) ram_addr8 = 8'(sp_q - 8'd1);
        else if (op == OP_STOR || op == OP_STORP) ram_addr8 = store_addr;
        else ram_addr8 = mem_addr;
      end
    endcase
  end

  ebrc_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (cmd_i.ram_read),
    .addr_i (ram_addr8[AW-1:0]),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  // ALU result for register-writing ops
  always_comb begin
    alu_res = '0;
    alu_wr  = 1'b1;
    flag_wr = 1'b1;
    case (op)
      OP_MOV_RR: begin alu_res = rs; flag_wr = 1'b0; end
      OP_MOV_RI: begin alu_res = lo_q; flag_wr = 1'b0; end
      OP_ADD_RR: alu_res = 8'(rd + rs);
      OP_ADD_RI: alu_res = 8'(rd + lo_q);
      OP_SUB_RR, OP_CMP_RR: alu_res = 8'(rd - rs);
      OP_SUB_RI, OP_CMP_RI: alu_res = 8'(rd - lo_q);
      OP_MUL_RR: alu_res = 8'(rd * rs);
      OP_MUL_RI: alu_res = 8'(rd * lo_q);
      OP_DIV_RR, OP_DIV_RI: alu_res = div_res;
      OP_AND_RR: alu_res = rd & rs;
      OP_AND_RI: alu_res = rd & lo_q;
      OP_OR_RR:  alu_res = rd | rs;
      OP_OR_RI:  alu_res = rd | lo_q;
      OP_XOR_RR: alu_res = rd ^ rs;
      OP_XOR_RI: alu_res = rd ^ lo_q;
      OP_NEG:    alu_res = 8'(-rd);
      default: begin alu_wr = 1'b0; flag_wr = 1'b0; end
    endcase
    if (op == OP_CMP_RR || op == OP_CMP_RI) alu_wr = 1'b0;
  end

  // execute: status, next state
  logic [3:0] st;
  logic [7:0] pc_n, sp_n, reg_wv;
  logic       reg_we, scr_v, key_stall;
  logic [7:0] scr_c;

  always_comb begin
    st = ST_OK;
    pc_n = 8'(pc_q + 8'd2);
    sp_n = sp_q;
    reg_we = alu_wr;
    reg_wv = alu_res;
    ram_we = 1'b0;
    ram_wdata = item_i.load_data;
    scr_v = 1'b0;
    scr_c = '0;
    key_stall = 1'b0;
    if (cmd_i.do_load) begin
      ram_we = item_i.load_address < RAM_TOP;
    end
    if (cmd_i.exec_commit) begin
      case (op)
        OP_DIV_RR: if (rs == 8'd0) begin st = ST_DIV_ZERO; reg_we = 1'b0; end
        OP_DIV_RI: if (lo_q == 8'd0) begin st = ST_DIV_ZERO; reg_we = 1'b0; end
        OP_JMP: if (lo_q >= RAM_TOP) st = ST_JUMP_RANGE; else pc_n = lo_q;
        OP_JEQ: if (zf_q) pc_n = lo_q;
        OP_JNE: if (!zf_q) pc_n = lo_q;
        OP_JGR: if (!zf_q && !sf_q) pc_n = lo_q;
        OP_JLS: if (sf_q) pc_n = lo_q;
        OP_CALL: begin
          if (sp_q == 8'd0) st = ST_CALL_OVF;
          else if (lo_q >= RAM_TOP) st = ST_CALL_RANGE;
          else begin
            sp_n = 8'(sp_q - 8'd1);
            ram_we = 1'b1;
            ram_wdata = 8'(pc_q + 8'd2);
            pc_n = lo_q;
          end
        end
        OP_RET: begin
          if (sp_q >= RAM_TOP) st = ST_RETURNED;
          else begin pc_n = ram_rdata; sp_n = 8'(sp_q + 8'd1); end
        end
        OP_LOAD, OP_LOADP: begin
          if (mem_addr < RAM_TOP) begin reg_we = 1'b1; reg_wv = ram_rdata; end
          else if (mem_addr == KEY_ADDR) begin
            if (item_i.key_char == NEWLINE_CHAR) key_stall = 1'b1;
            else begin reg_we = 1'b1; reg_wv = item_i.key_char; end
          end else st = ST_LOAD_RANGE;
        end
        OP_STOR, OP_STORP: begin
          if (store_addr < RAM_TOP) begin ram_we = 1'b1; ram_wdata = store_val; end
          else if (store_addr == SCREEN_ADDR) begin
            st = ST_SCREEN; scr_v = 1'b1; scr_c = store_val;
          end else st = ST_STORE_RANGE;
        end
        OP_PUSH: begin
          if (sp_q == 8'd0) st = ST_PUSH_OVF;
          else begin sp_n = 8'(sp_q - 8'd1); ram_we = 1'b1; ram_wdata = rd; end
        end
        OP_POP: begin
          if (sp_q >= RAM_TOP) st = ST_POP_UNF;
          else begin
            reg_we = 1'b1; reg_wv = ram_rdata; sp_n = 8'(sp_q + 8'd1);
          end
        end
        default: ;
      endcase
      if (key_stall) st = ST_KEY_WAIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q[0] <= 8'h30; regs_q[1] <= 8'h37; regs_q[2] <= 8'h32; regs_q[3] <= 8'h38;
      regs_q[4] <= 8'h32; regs_q[5] <= 8'h30; regs_q[6] <= 8'h30; regs_q[7] <= 8'h37;
      pc_q   <= '0;
      sp_q   <= RAM_TOP;
      zf_q   <= 1'b0;
      sf_q   <= 1'b0;
      halt_q <= 1'b0;
      tick_q <= '0;
      res_o  <= '0;
    end else begin
      if (cmd_i.do_load) begin
        res_o <= '{status: ST_OK, screen_char: 8'd0, screen_valid: 1'b0,
                   program_counter: pc_q, tick_count: tick_q};
      end else if (cmd_i.bad_pc) begin
        tick_q <= tick_q + 32'd1;
        halt_q <= 1'b1;
        res_o  <= '{status: ST_BAD_PC, screen_char: 8'd0, screen_valid: 1'b0,
                    program_counter: pc_q, tick_count: tick_q + 32'd1};
      end else if (cmd_i.exec_commit && key_stall) begin
        res_o <= '{status: ST_KEY_WAIT, screen_char: 8'd0, screen_valid: 1'b0,
                   program_counter: pc_q, tick_count: tick_q};
      end else if (cmd_i.exec_commit) begin
        tick_q <= tick_q + 32'd1;
        if (st >= ST_RETURNED) begin
          halt_q <= 1'b1;
          pc_q   <= 8'(pc_q + 8'd2);
        end else begin
          pc_q <= pc_n;
          sp_q <= sp_n;
          if (reg_we) regs_q[dr] <= reg_wv;
          if (flag_wr) begin
            zf_q <= (alu_res == 8'd0);
            sf_q <= alu_res[7];
          end
        end
        res_o <= '{status: st, screen_char: scr_c, screen_valid: scr_v,
                   program_counter: (st >= ST_RETURNED) ? 8'(pc_q + 8'd2) : pc_n,
                   tick_count: tick_q + 32'd1};
      end else if (cmd_i.latch_hi && halt_q) begin
        res_o <= '{status: ST_HALTED, screen_char: 8'd0, screen_valid: 1'b0,
                   program_counter: pc_q, tick_count: tick_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_hi) hi_q <= ram_rdata;
    if (cmd_i.latch_lo) lo_q <= ram_rdata;
  end

  assign stat_o.pc_ok = (pc_q <= PC_MAX);
  assign stat_o.needs_mem = (op == OP_RET) || (op == OP_POP) ||
                            (((op == OP_LOAD) || (op == OP_LOADP)) && (mem_addr < RAM_TOP));
  assign stat_o.needs_div = ((op == OP_DIV_RR) && (rs != 8'd0)) ||
                            ((op == OP_DIV_RI) && (lo_q != 8'd0));
  assign stat_o.div_done = div_done;
  assign stat_o.halted = halt_q;
endmodule

>>> rtl/ebrc_ctrl.sv
// ----------------------------------------------------------------------------
// ebrc_ctrl
// Step sequencer: fetch two bytes, optional RAM read or divide, retire.
// ----------------------------------------------------------------------------
module ebrc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command_i,
  output logic               out_valid,
  input  logic               out_stall,
  input  ebrc_pkg::dp_stat_t stat_i,
  output ebrc_pkg::dp_cmd_t  cmd_o
);
  import ebrc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_MEM, S_DIV, S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;
  logic   acc;

  // a new item is taken only when the result slot is free or being emptied
  assign in_stall = (state_q != S_IDLE) || (ov_q && out_stall);
  assign acc = in_valid && !in_stall;
  assign out_valid = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d = ov_q && out_stall;
    cmd_o = '0;
    cmd_o.addr_sel = ADDR_EXEC;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (command_i == CMD_LOAD) begin
            cmd_o.do_load = 1'b1;
            ov_d = 1'b1;
          end else if (stat_i.halted) begin
            cmd_o.latch_hi = 1'b1;
            ov_d = 1'b1;
          end else if (!stat_i.pc_ok) begin
            cmd_o.bad_pc = 1'b1;
            ov_d = 1'b1;
          end else begin
            cmd_o.ram_read = 1'b1;
            cmd_o.addr_sel = ADDR_PC;
            state_d = S_FETCH_HI;
          end
        end
      end
      S_FETCH_HI: begin
        cmd_o.latch_hi = 1'b1;
        cmd_o.ram_read = 1'b1;
        cmd_o.addr_sel = ADDR_PC1;
        state_d = S_FETCH_LO;
      end
      S_FETCH_LO: begin
        cmd_o.latch_lo = 1'b1;
        state_d = S_DECODE;
      end
      S_DECODE: begin
        if (stat_i.needs_div) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else if (stat_i.needs_mem) begin
          cmd_o.ram_read = 1'b1;
          state_d = S_MEM;
        end else begin
          state_d = S_EXEC;
        end
      end
      S_MEM: state_d = S_EXEC;
      S_DIV: if (stat_i.div_done) state_d = S_EXEC;
      S_EXEC: begin
        cmd_o.exec_commit = 1'b1;
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // a retire never overwrites a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec_commit |-> !ov_q || !out_stall)
    else $error("result overwritten");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall)
    else $error("input taken mid-step");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> state_q == S_DIV)
    else $error("divider start lost");
endmodule

>>> rtl/eight_bit_risc_core_step_top.sv
// ----------------------------------------------------------------------------
// eight_bit_risc_core_step_top
// 8-bit core: RAM load command and one-instruction step command.
// ----------------------------------------------------------------------------
// Each item is a load (one RAM byte written; a load address past the RAM is
// ignored) or a step that runs one instruction. A step passes through two RAM
// fetches through the single RAM port, a decode step, an execute step and the
// move into the output register. It adds a RAM read step when it reads RAM
// for LOAD/LOADP/RET/POP, and for a divide it waits on the bit-serial
// divider between decode and execute. Halted steps, loads and bad-PC steps
// answer straight from idle, with no fetch. One item is in flight at a time.
// A finished result moves into the output register; while that register is
// stalled the datapath can still hold one more result, so the input blocks
// while a step runs and otherwise only when both are full.
// The RAM has no reset; reading a never-written byte gives undefined data.
// ----------------------------------------------------------------------------
module eight_bit_risc_core_step_top #(
  parameter int RAM_BYTES = 254
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_stall,
  input  ebrc_pkg::in_item_t  in_data_i,
  output logic                out_valid,
  input  logic                out_stall,
  output ebrc_pkg::out_item_t out_data_o
);
  import ebrc_pkg::*;

  dp_cmd_t   cmd;
  dp_stat_t  stat;
  logic      dp_valid;
  logic      dp_blocked;
  out_item_t dp_res;

  // output register: takes the datapath result when empty or being emptied
  logic      out_valid_q, out_valid_d;
  out_item_t res_q;

  assign dp_blocked = out_valid_q && out_stall;

  ebrc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command_i(in_data_i.command),
    .out_valid(dp_valid),
    .out_stall(dp_blocked),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  // the step's key_char is held stable by the sender only at acceptance,
  // so it is captured there
  in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (in_valid && !in_stall) item_q <= in_data_i;
  end

  in_item_t item_use;
  assign item_use = cmd.do_load ? in_data_i : item_q;

  ebrc_datapath #(.RAM_BYTES(RAM_BYTES)) u_dp (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .item_i(item_use),
    .cmd_i (cmd),
    .stat_o(stat),
    .res_o (dp_res)
  );

  assign out_valid_d = dp_valid || dp_blocked;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (dp_valid && !dp_blocked) res_q <= dp_res;
    end
  end

  assign out_valid  = out_valid_q;
  assign out_data_o = res_q;
endmodule

>>> tb/sv/eight_bit_risc_core_step_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eight_bit_risc_core_step_top_test
// Self-checking bench for the 8-bit core: loads programs, single-steps them
// and checks every status, screen byte, PC and tick count against a
// cycle-free model of the core kept in the bench.
// ----------------------------------------------------------------------------
module eight_bit_risc_core_step_top_test;
  import ebrc_pkg::*;

  localparam int RAM_BYTES = 254;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_AT = 300;      // sender waits for an empty pipe here
  localparam int HOLD_AT = 450;       // receiver holds off for a long stretch here
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_ITEMS = 80;     // no idling over the last items

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data_i = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data_o;

  eight_bit_risc_core_step_top #(.RAM_BYTES(RAM_BYTES)) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_ni),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data_i (in_data_i),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data_o(out_data_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // --------------------------------------------------------------------------
  // Core model. The generator runs it ahead of time to plan each item; the
  // planned result only becomes an expectation once the item is accepted.
  // m_known tracks which RAM bytes hold defined data, so the generator never
  // lets the core read an unwritten byte.
  // --------------------------------------------------------------------------
  logic [7:0]  m_ram [RAM_BYTES];
  bit          m_known [RAM_BYTES];
  logic [7:0]  m_reg [8];
  logic [7:0]  m_pc, m_sp;
  bit          m_zf, m_sf, m_halt;
  logic [31:0] m_ticks;
  bit          ram_miss;
  logic [7:0]  ram_miss_addr;

  function automatic out_item_t core_predict(input in_item_t it, input bit commit);
    logic [7:0]  ram [RAM_BYTES];
    bit          known [RAM_BYTES];
    logic [7:0]  r [8];
    logic [7:0]  pc, sp, pc0, hi, lo, adr, v, f;
    logic [4:0]  op;
    logic [2:0]  d, s;
    bit          zf, sf, halt, upd;
    logic [31:0] tk, t0;
    logic [3:0]  st;
    int          num, den, q;
    out_item_t   res;
    ram = m_ram; known = m_known; r = m_reg;
    pc = m_pc; sp = m_sp; zf = m_zf; sf = m_sf; halt = m_halt; tk = m_ticks;
    res = '0;
    st = ST_OK;
    upd = 1'b0;
    f = '0;
    ram_miss = 1'b0;
    if (it.command == CMD_LOAD) begin
      if (it.load_address < RAM_BYTES) begin
        ram[it.load_address] = it.load_data;
        known[it.load_address] = 1'b1;
      end
    end else if (halt) begin
      st = ST_HALTED;
    end else begin
      pc0 = pc;
      t0 = tk;
      tk = tk + 1;
      if (pc > RAM_BYTES - 2) begin
        st = ST_BAD_PC;
      end else begin
        if (!known[pc]) begin ram_miss = 1'b1; ram_miss_addr = pc; end
        if (!known[pc + 1]) begin ram_miss = 1'b1; ram_miss_addr = pc + 1; end
        hi = ram[pc];
        lo = ram[pc + 1];
        pc = pc + 2;
        op = hi[7:3];
        d = hi[2:0];
        s = lo[2:0];
        case (op)
          OP_MOV_RR: r[d] = r[s];
          OP_MOV_RI: r[d] = lo;
          OP_ADD_RR: begin r[d] = r[d] + r[s]; f = r[d]; upd = 1; end
          OP_ADD_RI: begin r[d] = r[d] + lo; f = r[d]; upd = 1; end
          OP_SUB_RR: begin r[d] = r[d] - r[s]; f = r[d]; upd = 1; end
          OP_SUB_RI: begin r[d] = r[d] - lo; f = r[d]; upd = 1; end
          OP_MUL_RR: begin r[d] = r[d] * r[s]; f = r[d]; upd = 1; end
          OP_MUL_RI: begin r[d] = r[d] * lo; f = r[d]; upd = 1; end
          OP_DIV_RR: begin
            if (r[s] == 0) st = ST_DIV_ZERO;
            else begin r[d] = r[d] / r[s]; f = r[d]; upd = 1; end
          end
          OP_DIV_RI: begin
            if (lo == 0) st = ST_DIV_ZERO;
            else begin
              // unsigned register over signed immediate, toward zero
              num = int'(r[d]);
              den = lo[7] ? int'(lo) - 256 : int'(lo);
              q = num / den;
              r[d] = q[7:0];
              f = r[d];
              upd = 1;
            end
          end
          OP_CMP_RR: begin f = r[d] - r[s]; upd = 1; end
          OP_CMP_RI: begin f = r[d] - lo; upd = 1; end
          OP_JMP: begin
            if (lo >= RAM_BYTES) st = ST_JUMP_RANGE;
            else pc = lo;
          end
          OP_JEQ: if (zf) pc = lo;
          OP_JNE: if (!zf) pc = lo;
          OP_JGR: if (!zf && !sf) pc = lo;
          OP_JLS: if (sf) pc = lo;
          OP_CALL: begin
            if (sp == 0) st = ST_CALL_OVF;
            else if (lo >= RAM_BYTES) st = ST_CALL_RANGE;
            else begin
              sp = sp - 1;
              ram[sp] = pc;
              known[sp] = 1'b1;
              pc = lo;
            end
          end
          OP_RET: begin
            if (sp >= RAM_BYTES) st = ST_RETURNED;
            else begin
              if (!known[sp]) begin ram_miss = 1'b1; ram_miss_addr = sp; end
              pc = ram[sp];
              sp = sp + 1;
            end
          end
          OP_AND_RR: begin r[d] = r[d] & r[s]; f = r[d]; upd = 1; end
          OP_AND_RI: begin r[d] = r[d] & lo; f = r[d]; upd = 1; end
          OP_OR_RR:  begin r[d] = r[d] | r[s]; f = r[d]; upd = 1; end
          OP_OR_RI:  begin r[d] = r[d] | lo; f = r[d]; upd = 1; end
          OP_XOR_RR: begin r[d] = r[d] ^ r[s]; f = r[d]; upd = 1; end
          OP_XOR_RI: begin r[d] = r[d] ^ lo; f = r[d]; upd = 1; end
          OP_NEG:    begin r[d] = 8'd0 - r[d]; f = r[d]; upd = 1; end
          OP_LOAD, OP_LOADP: begin
            adr = (op == OP_LOAD) ? lo : r[s];
            if (adr < RAM_BYTES) begin
              if (!known[adr]) begin ram_miss = 1'b1; ram_miss_addr = adr; end
              r[d] = ram[adr];
            end else if (adr == KEY_ADDR) begin
              if (it.key_char == NEWLINE_CHAR) begin
                // key wait: step is undone
                pc = pc0;
                tk = t0;
                st = ST_KEY_WAIT;
              end else begin
                r[d] = it.key_char;
              end
            end else begin
              st = ST_LOAD_RANGE;
            end
          end
          OP_STOR, OP_STORP: begin
            v = (op == OP_STOR) ? r[d] : r[s];
            adr = (op == OP_STOR) ? lo : r[d];
            if (adr < RAM_BYTES) begin
              ram[adr] = v;
              known[adr] = 1'b1;
            end else if (adr == SCREEN_ADDR) begin
              res.screen_char = v;
              res.screen_valid = 1'b1;
              st = ST_SCREEN;
            end else begin
              st = ST_STORE_RANGE;
            end
          end
          OP_PUSH: begin
            if (sp == 0) st = ST_PUSH_OVF;
            else begin
              sp = sp - 1;
              ram[sp] = r[d];
              known[sp] = 1'b1;
            end
          end
          default: begin
            if (sp >= RAM_BYTES) st = ST_POP_UNF;
            else begin
              if (!known[sp]) begin ram_miss = 1'b1; ram_miss_addr = sp; end
              r[d] = ram[sp];
              sp = sp + 1;
            end
          end
        endcase
        if (upd) begin
          zf = (f == 0);
          sf = f[7];
        end
      end
      if (st >= ST_RETURNED) halt = 1'b1;
    end
    res.status = st;
    res.program_counter = pc;
    res.tick_count = tk;
    if (commit) begin
      m_ram = ram; m_known = known; m_reg = r;
      m_pc = pc; m_sp = sp; m_zf = zf; m_sf = sf; m_halt = halt; m_ticks = tk;
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Item queues and counters
  // --------------------------------------------------------------------------
  in_item_t  pending_items[$];
  out_item_t planned_results[$];
  out_item_t expected_results[$];
  int total_items = 0;
  int accepted_cnt = 0;
  int presented_cnt = 0;
  int result_cnt = 0;
  int mismatches = 0;
  int n_steps = 0, n_loads = 0, n_screen = 0, n_key_wait = 0;
  bit gen_done = 1'b0;

  task automatic queue_item(input in_item_t it);
    out_item_t r;
    r = core_predict(it, 1'b1);
    pending_items.push_back(it);
    planned_results.push_back(r);
    if (it.command == CMD_LOAD) n_loads++;
    else n_steps++;
    if (r.status == ST_SCREEN) n_screen++;
    if (r.status == ST_KEY_WAIT) n_key_wait++;
  endtask

  task automatic issue_load(input logic [7:0] adr, input logic [7:0] dat);
    in_item_t it;
    it.command = CMD_LOAD;
    it.load_address = adr;
    it.load_data = dat;
    it.key_char = 8'($urandom);
    queue_item(it);
  endtask

  // a step; any RAM byte it would read undefined is loaded first
  task automatic issue_step(input logic [7:0] key);
    in_item_t  it;
    out_item_t r;
    it.command = ~CMD_LOAD;
    it.load_address = 8'($urandom);
    it.load_data = 8'($urandom);
    it.key_char = key;
    r = core_predict(it, 1'b0);
    while (ram_miss) begin
      issue_load(ram_miss_addr, 8'($urandom));
      r = core_predict(it, 1'b0);
    end
    queue_item(it);
  endtask

  task automatic write_insn(input logic [4:0] op, input logic [2:0] d, input logic [7:0] lo);
    issue_load(m_pc, {op, d});
    issue_load(m_pc + 8'd1, lo);
  endtask

  // One random instruction at the current PC that keeps the core running:
  // either re-runs what is already there or plants a fresh instruction.
  task automatic random_step();
    logic [7:0] hi, lo, old_hi, old_lo, a, key;
    bit         old_kh, old_kl, found;
    logic [4:0] op;
    in_item_t   it;
    out_item_t  r;
    a = m_pc;
    found = 1'b0;
    hi = '0;
    lo = '0;
    key = ($urandom_range(0, 7) == 0) ? NEWLINE_CHAR : 8'($urandom);
    it.command = ~CMD_LOAD;
    it.load_address = '0;
    it.load_data = '0;
    it.key_char = key;
    old_hi = m_ram[a]; old_lo = m_ram[a + 1];
    old_kh = m_known[a]; old_kl = m_known[a + 1];
    for (int n = 0; n < 30 && !found; n++) begin
      if (old_kh && old_kl && $urandom_range(0, 9) < 3) begin
        hi = old_hi;
        lo = old_lo;
      end else begin
        op = 5'($urandom);
        hi = {op, 3'($urandom)};
        lo = 8'($urandom);
        if (op inside {OP_JMP, OP_JEQ, OP_JNE, OP_JGR, OP_JLS, OP_CALL} &&
            $urandom_range(0, 9) < 8)
          lo = 8'($urandom_range(0, RAM_BYTES - 2));
        if (op inside {OP_LOAD, OP_STOR} && $urandom_range(0, 9) < 3)
          lo = (op == OP_LOAD) ? KEY_ADDR : SCREEN_ADDR;
      end
      m_ram[a] = hi; m_ram[a + 1] = lo;
      m_known[a] = 1'b1; m_known[a + 1] = 1'b1;
      r = core_predict(it, 1'b0);
      m_ram[a] = old_hi; m_ram[a + 1] = old_lo;
      m_known[a] = old_kh; m_known[a + 1] = old_kl;
      found = (r.status < ST_RETURNED) && (r.program_counter <= RAM_BYTES - 2);
    end
    if (!found) begin
      // safe fallback: an immediate move, or a jump back when near the top
      if (a + 2 <= RAM_BYTES - 2) begin
        hi = {OP_MOV_RI, 3'($urandom)};
        lo = 8'($urandom);
      end else begin
        hi = {OP_JMP, 3'($urandom)};
        lo = 8'($urandom_range(0, RAM_BYTES - 2));
      end
    end
    if (!old_kh || old_hi != hi) issue_load(a, hi);
    if (!old_kl || old_lo != lo) issue_load(a + 8'd1, lo);
    issue_step(key);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus plan and end of run
  // --------------------------------------------------------------------------
  initial begin
    int err_kind;
    m_reg = '{8'h30, 8'h37, 8'h32, 8'h38, 8'h32, 8'h30, 8'h30, 8'h37};
    m_pc = '0; m_sp = 8'(RAM_BYTES);
    m_zf = 0; m_sf = 0; m_halt = 0; m_ticks = '0;
    foreach (m_known[i]) m_known[i] = 1'b0;
    foreach (m_ram[i]) m_ram[i] = '0;

    // directed: keyboard wait and read, screen write, signed divide, NEG,
    // loads at the address extremes and ignored loads past the RAM
    issue_load(8'd0, {OP_LOAD, 3'd0});
    issue_load(8'd1, KEY_ADDR);
    issue_step(NEWLINE_CHAR);
    issue_step(8'hFF);
    issue_load(8'd2, {OP_STOR, 3'd0});
    issue_load(8'd3, SCREEN_ADDR);
    issue_step(8'h00);
    issue_load(8'd4, {OP_DIV_RI, 3'd0});
    issue_load(8'd5, 8'h80);
    issue_step(8'h55);
    issue_load(8'd6, {OP_NEG, 3'd0});
    issue_load(8'd7, 8'h00);
    issue_step(8'hAA);
    issue_load(8'd253, 8'h00);
    issue_load(8'd253, 8'hFF);
    issue_load(8'd254, 8'h12);
    issue_load(8'd255, 8'hFF);

    // random programs: mostly running code, some stray loads as noise
    while (pending_items.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) issue_load(8'($urandom), 8'($urandom));
      else random_step();
    end

    // one fatal error halts the core for good, so it comes last
    err_kind = $urandom_range(0, 5);
    case (err_kind)
      0: write_insn(OP_DIV_RI, 3'($urandom), 8'h00);
      1: write_insn(OP_JMP, 3'($urandom), 8'($urandom_range(RAM_BYTES, 255)));
      2: write_insn(OP_LOAD, 3'($urandom), SCREEN_ADDR);
      3: write_insn(OP_STOR, 3'($urandom), KEY_ADDR);
      4: write_insn(m_sp != 0 ? OP_CALL : OP_PUSH, 3'($urandom), SCREEN_ADDR);
      default: write_insn(OP_JMP, 3'($urandom), 8'(RAM_BYTES - 1));
    endcase
    issue_step(8'($urandom));
    issue_step(8'($urandom));   // bad PC after the jump, else already halted
    issue_load(8'($urandom_range(0, RAM_BYTES - 1)), 8'($urandom));
    issue_step(8'($urandom));
    issue_step(NEWLINE_CHAR);
    total_items = pending_items.size();
    gen_done = 1'b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    wait (accepted_cnt == total_items && expected_results.size() == 0);
    repeat (40) @(posedge clk);
    $display("Ran %0d steps and %0d loads, %0d results checked", n_steps, n_loads,
             result_cnt);
    $display("Covered %0d screen writes, %0d key waits, error case %0d", n_screen,
             n_key_wait, err_kind);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Input side. Acceptance is seen at the rising edge; the item moves from
  // the planned store into the expected store at that point.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_ni && in_valid && !in_stall) begin
      pending_items.pop_front();
      expected_results.push_back(planned_results.pop_front());
      accepted_cnt <= accepted_cnt + 1;
    end
  end

  int  src_gap = 0;
  bit  drained = 1'b0;

  // driver: new item only once the current one has gone
  always @(negedge clk) begin
    logic     nv;
    in_item_t nd;
    bit       tail;
    nv = 1'b0;
    nd = in_data_i;
    tail = (total_items - accepted_cnt) < TAIL_ITEMS;
    if (!rst_ni || !gen_done) begin
      nv = 1'b0;
    end else if (in_valid && accepted_cnt < presented_cnt) begin
      nv = 1'b1;                        // still offered, unchanged
    end else if (pending_items.size() == 0) begin
      nv = 1'b0;
    end else if (accepted_cnt == DRAIN_AT && !drained) begin
      // sender pauses until every result so far is back
      if (expected_results.size() == 0) drained = 1'b1;
    end else if (src_gap > 0 && !tail) begin
      src_gap = src_gap - 1;
    end else if (!tail && accepted_cnt > 550 && accepted_cnt < 650) begin
      nv = 1'b1;                        // stretch with no source gaps
      nd = pending_items[0];
    end else if (!tail && $urandom_range(0, 9) == 0) begin
      src_gap = $urandom_range(1, 15) - 1;
    end else begin
      nv = 1'b1;
      nd = pending_items[0];
    end
    if (nv && !(in_valid && accepted_cnt < presented_cnt)) presented_cnt = presented_cnt + 1;
    in_valid <= nv;
    in_data_i <= nd;
  end

  // --------------------------------------------------------------------------
  // Output side: random stall bursts plus one long hold-off so the core
  // fills up and stalls its input while the driver keeps offering items.
  // --------------------------------------------------------------------------
  int sink_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(negedge clk) begin
    logic ns;
    bit   tail;
    ns = 1'b0;
    tail = gen_done && (total_items - accepted_cnt) < TAIL_ITEMS;
    if (!rst_ni) begin
      ns = 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      ns = 1'b1;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      ns = 1'b1;
    end else if (tail || (accepted_cnt > 600 && accepted_cnt < 700)) begin
      ns = 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap = sink_gap - 1;
      ns = 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(1, 15) - 1;
      ns = 1'b1;
    end
    out_stall <= ns;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h expected 0x%0h", result_cnt, what, got,
             want);
    mismatches++;
  endtask

  // monitor: every accepted result against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_data_o.status), 32'hX);
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.status !== want.status)
          report_mismatch("status", 32'(out_data_o.status), 32'(want.status));
        if (out_data_o.screen_char !== want.screen_char)
          report_mismatch("screen_char", 32'(out_data_o.screen_char), 32'(want.screen_char));
        if (out_data_o.screen_valid !== want.screen_valid)
          report_mismatch("screen_valid", 32'(out_data_o.screen_valid),
                          32'(want.screen_valid));
        if (out_data_o.program_counter !== want.program_counter)
          report_mismatch("program_counter", 32'(out_data_o.program_counter),
                          32'(want.program_counter));
        if (out_data_o.tick_count !== want.tick_count)
          report_mismatch("tick_count", out_data_o.tick_count, want.tick_count);
      end
      result_cnt <= result_cnt + 1;
    end
  end

endmodule

>>> filelist.f
rtl/ebrc_pkg.sv
rtl/ebrc_ram.sv
rtl/ebrc_div.sv
rtl/ebrc_datapath.sv
rtl/ebrc_ctrl.sv
rtl/eight_bit_risc_core_step_top.sv
tb/sv/eight_bit_risc_core_step_top_test.sv
